/* rtl/pcs_pkg.sv */
// Shared types and sizes for the pair conflict suppressor.
package pcs_pkg;

    localparam int MAX_PAIRS    = 32;
    localparam int BLOB_ID_BITS = 6;
    localparam int ID_W         = 6;
    localparam int VAL_W        = 16;
    localparam int INDEX_W      = 5;
    localparam int SLOT_W       = $clog2(MAX_PAIRS);

    typedef logic [ID_W-1:0]  blob_id_t;
    typedef logic [VAL_W-1:0] fix_val_t;

    // one pairing as broadcast to the cell row
    typedef struct packed {
        logic [BLOB_ID_BITS-1:0] left_id;
        logic [BLOB_ID_BITS-1:0] right_id;
        fix_val_t                width;
        fix_val_t                error;
    } pair_t;

    // row-wide commands
    typedef struct packed {
        logic insert;
        logic shift;
        logic clear;
    } cell_ctrl_t;

    // what a cell hands to its neighbors
    typedef struct packed {
        logic valid;
        logic mark;
    } link_t;

    typedef enum logic [1:0] {
        ST_LOAD = 2'b01,
        ST_EMIT = 2'b10
    } state_t;

endpackage

/* rtl/pcs_cell.sv */
// One storage cell of the candidate row: holds a pairing and its removal mark.
module pcs_cell
    import pcs_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  cell_ctrl_t ctrl,
    input  pair_t      new_pair,
    input  logic       new_mark,
    input  logic       prev_valid,
    input  link_t      next_link,
    output link_t      link,
    output logic       hit_new
);

    logic  valid_reg, valid_next;
    logic  mark_reg, mark_next;
    pair_t pair_reg, pair_next;

    logic same_blob;
    logic cross_blob;
    logic wider;
    logic worse;
    logic lose_self;
    logic take;

    always_comb begin
        same_blob  = (pair_reg.left_id == new_pair.left_id) ||
                     (pair_reg.right_id == new_pair.right_id);
        cross_blob = (pair_reg.left_id == new_pair.right_id) ||
                     (pair_reg.right_id == new_pair.left_id);
        wider      = pair_reg.width > new_pair.width;
        worse      = pair_reg.error > new_pair.error;
        // ties go against the newcomer
        lose_self  = valid_reg && (same_blob ? wider : (cross_blob && worse));
        hit_new    = valid_reg && (same_blob ? !wider : (cross_blob && !worse));
        take       = ctrl.insert && !valid_reg && prev_valid;
    end

    always_comb begin
        valid_next = valid_reg;
        mark_next  = mark_reg;
        pair_next  = pair_reg;
        if (ctrl.clear) begin
            valid_next = 1'b0;
            mark_next  = 1'b0;
        end else if (ctrl.shift) begin
            valid_next = next_link.valid;
            mark_next  = next_link.mark;
        end else if (take) begin
            valid_next = 1'b1;
            mark_next  = new_mark;
            pair_next  = new_pair;
        end else if (ctrl.insert && lose_self) begin
            mark_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            mark_reg  <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            mark_reg  <= mark_next;
        end
        pair_reg <= pair_next;
    end

    assign link.valid = valid_reg;
    assign link.mark  = mark_reg;

endmodule

/* rtl/pair_conflict_suppressor_top.sv */
// Top level: cell row of stored pairings, load/emit control and result port.
//
// Pairings are taken one per cycle while a frame loads; each one is compared
// against every stored candidate in the same cycle and written into the first
// free cell of a 32-cell row. The item flagged last_pair switches the block to
// emission: one result per stored candidate, in load order, one per cycle when
// the sink is ready, shifted out of the head of the row. No pairing is taken
// during emission. Pairings beyond 32 are dropped and reported through
// overflow on every result of the frame.
module pair_conflict_suppressor_top
    import pcs_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [ID_W-1:0]     s_left_blob,
    input  logic [ID_W-1:0]     s_right_blob,
    input  logic [VAL_W-1:0]    s_pair_width,
    input  logic [VAL_W-1:0]    s_match_error,
    input  logic                s_last_pair,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [INDEX_W-1:0]  m_pair_index,
    output logic                m_keep,
    output logic                m_overflow,
    output logic                m_last_result
);

    state_t            state_reg, state_next;
    logic [SLOT_W-1:0] index_reg, index_next;
    logic              dropped_reg, dropped_next;

    link_t             links [MAX_PAIRS+1];
    logic [MAX_PAIRS-1:0] hits;
    cell_ctrl_t        ctrl;
    pair_t             new_pair;
    logic              new_mark;
    logic              s_fire;
    logic              m_fire;
    logic              full;

    assign s_ready = (state_reg == ST_LOAD);
    assign m_valid = (state_reg == ST_EMIT);
    assign s_fire  = s_valid && s_ready;
    assign m_fire  = m_valid && m_ready;
    assign full    = links[MAX_PAIRS-1].valid;

    assign new_pair.left_id  = s_left_blob[BLOB_ID_BITS-1:0];
    assign new_pair.right_id = s_right_blob[BLOB_ID_BITS-1:0];
    assign new_pair.width    = s_pair_width;
    assign new_pair.error    = s_match_error;
    assign new_mark          = |hits;

    assign ctrl.insert = s_fire && !full;
    assign ctrl.shift  = m_fire;
    assign ctrl.clear  = m_fire && m_last_result;

    assign links[MAX_PAIRS] = '0;

    genvar k;
    generate
        for (k = 0; k < MAX_PAIRS; k++) begin : g_cell
            logic prev_valid;
            if (k == 0) begin : g_head
                assign prev_valid = 1'b1;
            end else begin : g_body
                assign prev_valid = links[k-1].valid;
            end
            pcs_cell u_cell (
                .aclk       (aclk),
                .aresetn    (aresetn),
                .ctrl       (ctrl),
                .new_pair   (new_pair),
                .new_mark   (new_mark),
                .prev_valid (prev_valid),
                .next_link  (links[k+1]),
                .link       (links[k]),
                .hit_new    (hits[k])
            );
        end
    endgenerate

    // head of the row is the oldest unreported candidate
    assign m_pair_index  = INDEX_W'(index_reg);
    assign m_keep        = !links[0].mark;
    assign m_overflow    = dropped_reg;
    assign m_last_result = !links[1].valid;

    always_comb begin
        state_next   = state_reg;
        index_next   = index_reg;
        dropped_next = dropped_reg;
        case (state_reg)
            ST_LOAD: begin
                if (s_fire) begin
                    if (full) begin
                        dropped_next = 1'b1;
                    end
                    if (s_last_pair) begin
                        state_next = ST_EMIT;
                        index_next = '0;
                    end
                end
            end
            ST_EMIT: begin
                if (m_fire) begin
                    index_next = index_reg + 1'b1;
                    if (m_last_result) begin
                        state_next   = ST_LOAD;
                        dropped_next = 1'b0;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            index_reg   <= '0;
            dropped_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            index_reg   <= index_next;
            dropped_reg <= dropped_next;
        end
    end

endmodule
